// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the frame store block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and idle while rst is high.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst is high.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mfb_pkg.sv =====
// Types and fixed constants of the one-bit frame store with rectangle fill.
package mfb_pkg;

  localparam int ACT_W   = 2;
  localparam int COORD_W = 16;
  localparam int BIDX_W  = 15;
  localparam int BYTE_W  = 8;
  localparam int DIM_W   = 10;
  localparam int CFG_AW  = 3;

  localparam logic [DIM_W-1:0] DIM_RESET = 10'd256;

  // Action codes carried in the input tuser.
  localparam logic [ACT_W-1:0] ACT_FILL   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INVERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  // Register select, taken from paddr[2].
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FSETUP,
    ST_FMUL,
    ST_FRD,
    ST_FWR,
    ST_ISETUP,
    ST_IRD,
    ST_IWR,
    ST_RRD,
    ST_RWAIT,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/mfb_ram.sv =====
// Single-port-write, single-read byte memory with registered read data.
module mfb_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mono_framebuffer_rect_fill.sv =====
// Top level of the one-bit packed frame store with rectangle fill, invert and read.
`include "assert_macros.svh"

// One-bit frame store, MSB-first, pixel (x, y) at bit x + y*W. After reset the block
// runs a clearing pass that writes zero to all MAX_WIDTH*MAX_HEIGHT/8 bytes (32768 at
// the defaults) and holds s_tready low until it ends. Every item then goes through one
// sequencer that works on the single frame memory: a fill sets up and clips, forms the
// row base, then reads and writes back the byte of each in-frame pixel before its result
// step (going straight to the result when nothing is drawn); an invert sets up, then
// reads and writes back each byte of the active area; a read reads the byte, waits for
// the registered data and moves to the result; the unused action code goes straight to
// the result. A result beat that has not been taken yet holds the sequencer in its last
// step until it leaves. One result beat leaves for every input beat; its read_byte is
// the complemented store byte for an in-range read and zero for every other case.
module mono_framebuffer_rect_fill
  import mfb_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic              clk,
  input  logic              rst,
  // stream in
  input  logic              s_tvalid,
  output logic              s_tready,
  // rect_x[15:0], rect_y[31:16], rect_w[47:32], rect_h[63:48], pixel_on[64],
  // invert_value[65], byte_index[80:66], zero pad [87:81]
  input  logic [87:0]       s_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]  s_tuser,
  // stream out
  output logic              m_tvalid,
  input  logic              m_tready,
  // read_byte[7:0]
  output logic [BYTE_W-1:0] m_tdata,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int STORE_BYTES = MAX_WIDTH * MAX_HEIGHT / 8;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int LW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = WW + HW;

  // Configuration registers.
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        frame_width <= pwdata[DIM_W-1:0];
      end else begin
        frame_height <= pwdata[DIM_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_HEIGHT) begin
      prdata = 32'(frame_height);
    end else begin
      prdata = 32'(frame_width);
    end
  end

  // Effective frame size, clamped to the store.
  logic [WW-1:0] fw;
  logic [HW-1:0] fh;
  assign fw = (32'(frame_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(frame_width);
  assign fh = (32'(frame_height) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(frame_height);

  state_t state;
  state_t state_next;

  // Latched item.
  logic [ACT_W-1:0]          act;
  logic signed [COORD_W-1:0] rect_x;
  logic signed [COORD_W-1:0] rect_y;
  logic signed [COORD_W-1:0] rect_w;
  logic signed [COORD_W-1:0] rect_h;
  logic                      draw_on;
  logic                      inv_val;
  logic [BIDX_W-1:0]         byte_idx;

  logic                      colour_invert;

  // Walk registers.
  logic [WW-1:0]  x_start;
  logic [WW-1:0]  x_end;
  logic [WW-1:0]  cur_x;
  logic [HW-1:0]  y_cur;
  logic [HW-1:0]  y_end;
  logic [LW:0]    row_base;
  logic [AW:0]    byte_cnt;
  logic [AW-1:0]  cur_b;
  logic [AW-1:0]  clr_cnt;
  logic           idx_ok;
  logic [BYTE_W-1:0] res_byte;

  // Memory port.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  mfb_ram #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Rectangle clipping, exact in 18-bit signed arithmetic.
  logic signed [17:0] x_lo, x_sum, x_hi, fw_s;
  logic signed [17:0] y_lo, y_sum, y_hi, fh_s;
  logic               rect_empty;

  always_comb begin
    fw_s  = $signed(18'(fw));
    fh_s  = $signed(18'(fh));
    x_lo  = (rect_x < 16'sd0) ? 18'sd0 : 18'(rect_x);
    y_lo  = (rect_y < 16'sd0) ? 18'sd0 : 18'(rect_y);
    x_sum = 18'(rect_x) + 18'(rect_w);
    y_sum = 18'(rect_y) + 18'(rect_h);
    x_hi  = (x_sum > fw_s) ? fw_s : x_sum;
    y_hi  = (y_sum > fh_s) ? fh_s : y_sum;
    rect_empty = (rect_w <= 16'sd0) || (rect_h <= 16'sd0) ||
                 (x_lo >= x_hi) || (y_lo >= y_hi);
  end

  // The one multiplier: row base for a fill, active pixel count for an invert.
  logic [HW-1:0] mul_b;
  logic [PW-1:0] mul_p;
  assign mul_b = (state == ST_ISETUP) ? fh : y_cur;
  assign mul_p = PW'(fw) * PW'(mul_b);

  logic [LW-1:0] pix_lin;
  logic [7:0]    pix_mask;
  logic          x_last;
  logic          y_last;
  logic          b_last;

  assign pix_lin  = LW'(row_base + (LW+1)'(cur_x));
  assign pix_mask = 8'h80 >> pix_lin[2:0];
  assign x_last   = (WW'(cur_x + 1'b1) == x_end);
  assign y_last   = (HW'(y_cur + 1'b1) == y_end);
  assign b_last   = ((AW+1)'({1'b0, cur_b} + 1'b1) == byte_cnt);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(STORE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            ACT_FILL:   state_next = ST_FSETUP;
            ACT_INVERT: state_next = ST_ISETUP;
            ACT_READ:   state_next = ST_RRD;
            default:    state_next = ST_OUT;
          endcase
        end
      end
      ST_FSETUP:  state_next = rect_empty ? ST_OUT : ST_FMUL;
      ST_FMUL:    state_next = ST_FRD;
      ST_FRD:     state_next = ST_FWR;
      ST_FWR:     state_next = (x_last && y_last) ? ST_OUT : ST_FRD;
      ST_ISETUP:  state_next = (mul_p[PW-1:3] == '0) ? ST_OUT : ST_IRD;
      ST_IRD:     state_next = ST_IWR;
      ST_IWR:     state_next = b_last ? ST_OUT : ST_IRD;
      ST_RRD:     state_next = ST_RWAIT;
      ST_RWAIT:   state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pix_lin[LW-1:3];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = pix_lin[LW-1:3];
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_FRD: begin
        ram_re = 1'b1;
      end
      ST_FWR: begin
        ram_we    = 1'b1;
        ram_wdata = draw_on ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
      end
      ST_IRD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_b;
      end
      ST_IWR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_b;
        ram_wdata = ~ram_rdata;
      end
      ST_RRD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(byte_idx);
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      colour_invert <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= AW'(clr_cnt + 1'b1);
      end
      if (state == ST_ISETUP) begin
        colour_invert <= inv_val;
      end
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        act      <= s_tuser;
        rect_x   <= s_tdata[15:0];
        rect_y   <= s_tdata[31:16];
        rect_w   <= s_tdata[47:32];
        rect_h   <= s_tdata[63:48];
        draw_on  <= s_tdata[64] ^ colour_invert;
        inv_val  <= s_tdata[65];
        byte_idx <= s_tdata[80:66];
        res_byte <= '0;
      end
      ST_FSETUP: begin
        x_start <= WW'(x_lo);
        x_end   <= WW'(x_hi);
        y_cur   <= HW'(y_lo);
        y_end   <= HW'(y_hi);
      end
      ST_FMUL: begin
        row_base <= (LW+1)'(mul_p);
        cur_x    <= x_start;
      end
      ST_FWR: begin
        if (x_last) begin
          cur_x    <= x_start;
          y_cur    <= HW'(y_cur + 1'b1);
          row_base <= (LW+1)'(row_base + (LW+1)'(fw));
        end else begin
          cur_x <= WW'(cur_x + 1'b1);
        end
      end
      ST_ISETUP: begin
        byte_cnt <= (AW+1)'(mul_p >> 3);
        cur_b    <= '0;
      end
      ST_IWR: begin
        cur_b <= AW'(cur_b + 1'b1);
      end
      ST_RRD: begin
        idx_ok <= (32'(byte_idx) < 32'(STORE_BYTES));
      end
      ST_RWAIT: begin
        res_byte <= idx_ok ? ~ram_rdata : '0;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= res_byte;
        end
      end
      default: begin
        act <= act;
      end
    endcase
  end

  // A read result is only loaded for a read action.
  `CHK_IMPL(a_read_only_on_read, state == ST_RWAIT, act == ACT_READ,
    "read completion reached for a non-read action")
  `CHK_NEXT(a_accept_starts_work, s_tvalid && s_tready, state != ST_IDLE,
    "accepted beat did not start the sequencer")
  `CHK_IMPL(a_write_in_store, ram_we, 32'(ram_waddr) < 32'(STORE_BYTES),
    "frame memory write beyond the store")
  `CHK_IMPL(a_pixel_in_rect, state == ST_FWR, (cur_x < x_end) && (y_cur < y_end),
    "fill walk left the clipped rectangle")

endmodule
